/* hw/rtl/cfpm_pkg.sv */
`timescale 1ns / 1ps

package cfpm_pkg;

  // Line store geometry
  localparam int unsigned MaxWidth = 4096;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned DimW     = 13;
  localparam int unsigned PixW     = 8;
  localparam int unsigned SumW     = 11;

  // Divide by 5 as multiply by reciprocal, then shift right by RecipShift
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW     = 15;
  localparam logic [RecipW-1:0] Recip5 = RecipW'((1 << RecipShift) / 5 + 2);

  // Configuration registers
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  // Item opcodes
  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [PixW-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] avg_pixel;
    logic            end_of_frame;
  } out_item_t;

  // Per-item info carried from the sequencer to the window stage
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            col_zero;
    logic            last_col;
    logic            first_row;
    logic            eof;
    logic [PixW-1:0] below;
  } s1_info_t;

endpackage

/* hw/rtl/cfpm_ram.sv */
`timescale 1ns / 1ps

module cfpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/cfpm_seq.sv */
`timescale 1ns / 1ps

module cfpm_seq
  import cfpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DimW-1:0]     cfg_wdata_i,
  // input beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  // line store ports
  output logic                mid_we_o,
  output logic [ColW-1:0]     mid_waddr_o,
  output logic [PixW-1:0]     mid_wdata_o,
  output logic                rd_en_o,
  output logic [ColW-1:0]     mid_raddr_o,
  output logic [ColW-1:0]     above_raddr_o,
  // window stage
  output logic                s1_valid_o,
  output s1_info_t            s1_info_o,
  input  logic                s1_adv_i
);

  logic [DimW-1:0] width_q, height_q;
  logic [ColW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic            s1_valid_q;
  s1_info_t        s1_info_q, s1_info_d;

  logic [DimW-1:0] w_eff, h_eff;
  logic            accept, last_col, drain_row;
  logic [PixW-1:0] below;

  // Config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgImageWidth:  width_q  <= cfg_wdata_i;
        CfgImageHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective frame size
  always_comb begin
    if (width_q < DimW'(2)) begin
      w_eff = DimW'(2);
    end else if (width_q > DimW'(MaxWidth)) begin
      w_eff = DimW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? DimW'(1) : height_q;
  end

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || s1_adv_i;

  assign last_col  = ({1'b0, col_q} + DimW'(1)) >= w_eff;
  assign drain_row = row_q >= h_eff;
  assign below     = (in_item_i.opcode == OpDrain || drain_row) ? '0 : in_item_i.pixel;

  // Line store access: middle row written now; right neighbor read ahead,
  // or column 0 prefetched on the last column of a row
  assign mid_we_o      = accept;
  assign mid_waddr_o   = col_q;
  assign mid_wdata_o   = below;
  assign rd_en_o       = accept;
  assign mid_raddr_o   = last_col ? '0 : col_q + ColW'(1);
  assign above_raddr_o = col_q;

  // Position counters and stage-1 info
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = drain_row ? '0 : row_q + DimW'(1);
    end else begin
      col_d = col_q + ColW'(1);
    end
    s1_info_d.col       = col_q;
    s1_info_d.col_zero  = (col_q == '0);
    s1_info_d.last_col  = last_col;
    s1_info_d.first_row = (row_q == '0);
    s1_info_d.eof       = drain_row && last_col;
    s1_info_d.below     = below;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= s1_info_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_info_o  = s1_info_q;

endmodule

/* hw/rtl/cfpm_window.sv */
`timescale 1ns / 1ps

module cfpm_window
  import cfpm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s1_valid_i,
  input  s1_info_t        s1_info_i,
  output logic            s1_adv_o,
  input  logic [PixW-1:0] mid_rdata_i,
  input  logic [PixW-1:0] above_rdata_i,
  // above-row write back
  output logic            above_we_o,
  output logic [ColW-1:0] above_waddr_o,
  output logic [PixW-1:0] above_wdata_o,
  // result beats
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  logic [PixW-1:0] left_q, centre_q, right_q, pref_q;
  logic [PixW-1:0] left_d, centre_d, right_d;
  logic [SumW-1:0] sum;
  logic [SumW+RecipW-1:0] prod;
  logic            has_res;
  logic            out_valid_q;
  out_item_t       out_item_q;

  assign has_res  = !s1_info_i.first_row;
  assign s1_adv_o = s1_valid_i && (!has_res || !out_valid_q || out_ready_i);

  // Slide the middle-row window
  always_comb begin
    if (s1_info_i.col_zero) begin
      left_d   = '0;
      centre_d = pref_q;
    end else begin
      left_d   = centre_q;
      centre_d = right_q;
    end
    right_d = s1_info_i.last_col ? '0 : mid_rdata_i;
  end

  // Cross sum and divide by 5
  assign sum  = SumW'(left_d) + SumW'(centre_d) + SumW'(right_d)
              + SumW'(above_rdata_i) + SumW'(s1_info_i.below);
  assign prod = (SumW+RecipW)'(sum) * (SumW+RecipW)'(Recip5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      centre_q <= '0;
      right_q  <= '0;
    end else if (s1_adv_o) begin
      left_q   <= left_d;
      centre_q <= centre_d;
      right_q  <= right_d;
    end
  end

  // Column 0 of the middle row, read during the last column
  always_ff @(posedge clk_i) begin
    if (s1_adv_o && s1_info_i.last_col) begin
      pref_q <= mid_rdata_i;
    end
  end

  // Centre pixel moves up into the above row
  assign above_we_o    = s1_adv_o;
  assign above_waddr_o = s1_info_i.col;
  assign above_wdata_o = s1_info_i.first_row ? '0 : centre_d;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv_o && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_o && has_res) begin
      out_item_q.avg_pixel    <= prod[RecipShift +: PixW];
      out_item_q.end_of_frame <= s1_info_i.eof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* hw/rtl/cross_five_point_mean_filter_top.sv */
`timescale 1ns / 1ps
// Five-point cross mean filter for 8-bit grayscale pixels in raster order.
// Input channel (in_valid_i/in_ready_o, in_item_i): one pixel or drain beat
// per cycle. Output channel (out_valid_o/out_ready_i, out_item_o): the
// truncated mean of each pixel and its four neighbors, zero outside the
// frame, delivered one row behind the input. Row 0 produces no results;
// after the last row, send image_width drain beats to flush the bottom row.
// end_of_frame marks the last result, then a new frame begins.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 = image_width,
// index 1 = image_height; always ready, write only while idle.
// Throughput: one beat per cycle while the receiver keeps up, set by the
// line store read/write ports. A result passes through the line store read
// register, then the window/divide into the output register.
// When the receiver stalls, the output register holds its beat, one more
// beat can sit in the window stage, and then in_ready_o drops.
// Reset clears the counters, window and config (640 x 480); line store
// contents stay undefined and need no clearing pass.
module cross_five_point_mean_filter_top
  import cfpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);

  logic            mid_we, rd_en, above_we, s1_valid, s1_adv;
  logic [ColW-1:0] mid_waddr, mid_raddr, above_raddr, above_waddr;
  logic [PixW-1:0] mid_wdata, mid_rdata, above_rdata, above_wdata;
  s1_info_t        s1_info;

  // Counters, config and line store addressing
  cfpm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .mid_we_o      (mid_we),
    .mid_waddr_o   (mid_waddr),
    .mid_wdata_o   (mid_wdata),
    .rd_en_o       (rd_en),
    .mid_raddr_o   (mid_raddr),
    .above_raddr_o (above_raddr),
    .s1_valid_o    (s1_valid),
    .s1_info_o     (s1_info),
    .s1_adv_i      (s1_adv)
  );

  // Current (middle) row store
  cfpm_ram #(.Width(PixW), .Depth(MaxWidth)) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (mid_we),
    .waddr_i (mid_waddr),
    .wdata_i (mid_wdata),
    .re_i    (rd_en),
    .raddr_i (mid_raddr),
    .rdata_o (mid_rdata)
  );

  // Row above store
  cfpm_ram #(.Width(PixW), .Depth(MaxWidth)) u_above_ram (
    .clk_i   (clk_i),
    .we_i    (above_we),
    .waddr_i (above_waddr),
    .wdata_i (above_wdata),
    .re_i    (rd_en),
    .raddr_i (above_raddr),
    .rdata_o (above_rdata)
  );

  // Window, divide and output register
  cfpm_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_info_i     (s1_info),
    .s1_adv_o      (s1_adv),
    .mid_rdata_i   (mid_rdata),
    .above_rdata_i (above_rdata),
    .above_we_o    (above_we),
    .above_waddr_o (above_waddr),
    .above_wdata_o (above_wdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

endmodule
